>>> rtl/core/slrp_pkg.sv
package slrp_pkg;

  // Number of list cells.
  localparam int unsigned MAX_LEN = 64;

  // Field widths.
  localparam int unsigned OP_W  = 2;
  localparam int unsigned POS_W = 6;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned LEN_W = 7;

  // Width of a count that holds any length up to MAX_LEN and any register value.
  localparam int unsigned CNT_W = ($clog2(MAX_LEN + 1) > LEN_W) ?
                                  $clog2(MAX_LEN + 1) : LEN_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_REPLACE = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic             load;
    logic             seed;
    logic             clr;
    logic             swap_up;
    logic             swap_dn;
    logic [VAL_W-1:0] wdata;
  } cell_ctrl_t;

  // Per-cell status back to the sequencer.
  typedef struct packed {
    logic tok;
    logic up_ok;
    logic dn_ok;
  } cell_stat_t;

  typedef struct packed {
    logic [POS_W-1:0] new_position;
    logic             odd_parity;
    logic [VAL_W-1:0] read_value;
    logic             bad_position;
  } rsp_t;

endpackage

>>> rtl/core/slrp_if.sv
interface slrp_req_if;
  logic                        valid;
  logic                        ready;
  logic [slrp_pkg::OP_W-1:0]   op;
  logic [slrp_pkg::POS_W-1:0]  position;
  logic [slrp_pkg::VAL_W-1:0]  value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface slrp_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [slrp_pkg::POS_W-1:0]  new_position;
  logic                        odd_parity;
  logic [slrp_pkg::VAL_W-1:0]  read_value;
  logic                        bad_position;

  modport source (output valid, output new_position, output odd_parity,
                  output read_value, output bad_position, input ready);
  modport sink   (input valid, input new_position, input odd_parity,
                  input read_value, input bad_position, output ready);
endinterface

interface slrp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [slrp_pkg::LEN_W-1:0]  list_length;

  modport source (output valid, output list_length, input ready);
  modport sink   (input valid, input list_length, output ready);
endinterface

>>> rtl/core/sorted_list_resort_with_parity_core.sv
// Sorted list of up to MAX_LEN 16-bit entries held in a row of cells, one entry per
// cell. Every response first enters a holding slot and moves to the output register at
// the next edge if that register is free; a new request is taken only once the holding
// slot is empty. For a load, a read, a bad position or the unused op code, the request
// is taken and its response moves to the output register once that is free; only then
// can the next request be taken. A replace writes the new value into its cell, which
// then holds a token that moves one cell per cycle by swapping with a neighbor; once no
// swap is left, the move ends and the holding slot is filled. A response may wait at
// the output while the next request is worked on. Reset clears all entries at once.
// The list length register is written through its own channel, which is always ready.
module sorted_list_resort_with_parity_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  slrp_req_if.sink    req_i,
  slrp_rsp_if.source  rsp_o,
  slrp_cfg_if.sink    cfg_i
);

  typedef enum logic {ST_IDLE, ST_MOVE} state_e;
  typedef enum logic [1:0] {DIR_NONE, DIR_UP, DIR_DN} dir_e;

  localparam int unsigned N = slrp_pkg::MAX_LEN;

  state_e                        state_q, state_d;
  dir_e                          dir_q, dir_d;
  logic [slrp_pkg::LEN_W-1:0]    len_q, len_d;
  logic [slrp_pkg::POS_W-1:0]    pos_q, pos_d;
  logic                          par_q, par_d;
  logic                          pend_valid_q, pend_valid_d;
  slrp_pkg::rsp_t                pend_q, pend_d;
  logic                          rsp_valid_q, rsp_valid_d;
  slrp_pkg::rsp_t                rsp_q, rsp_d;

  logic [slrp_pkg::CNT_W-1:0]    used_len;
  logic [slrp_pkg::CNT_W-1:0]    req_pos;
  logic                          req_acc;
  logic                          pos_ok;
  slrp_pkg::cell_ctrl_t          ctrl;
  logic [N-1:0]                  sel;
  logic [N-1:0]                  up_lim;
  logic [N-1:0]                  dn_lim;
  logic [slrp_pkg::VAL_W-1:0]    cell_val [N];
  slrp_pkg::cell_stat_t          stat [N];
  logic [N-1:0]                  tok;
  logic [N-1:0]                  up_vec;
  logic [N-1:0]                  dn_vec;
  logic                          up_any;
  logic                          dn_any;
  logic [slrp_pkg::VAL_W-1:0]    rd_val;

  assign used_len = (slrp_pkg::CNT_W'(len_q) > slrp_pkg::CNT_W'(N)) ?
                    slrp_pkg::CNT_W'(N) : slrp_pkg::CNT_W'(len_q);
  assign req_pos  = slrp_pkg::CNT_W'(req_i.position);
  assign pos_ok   = req_pos < used_len;

  assign req_i.ready = (state_q == ST_IDLE) && !pend_valid_q;
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [slrp_pkg::VAL_W-1:0] left_val;
    logic                       left_tok;
    logic [slrp_pkg::VAL_W-1:0] right_val;
    logic                       right_tok;

    assign sel[i]    = req_pos == slrp_pkg::CNT_W'(i);
    assign up_lim[i] = slrp_pkg::CNT_W'(i + 1) < used_len;
    assign dn_lim[i] = (i > 0);

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_tok = 1'b0;
    end else begin : g_inner_l
      assign left_val = cell_val[i-1];
      assign left_tok = stat[i-1].tok;
    end

    if (i == N - 1) begin : g_last
      assign right_val = '0;
      assign right_tok = 1'b0;
    end else begin : g_inner_r
      assign right_val = cell_val[i+1];
      assign right_tok = stat[i+1].tok;
    end

    slrp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .sel_i       (sel[i]),
      .up_lim_i    (up_lim[i]),
      .dn_lim_i    (dn_lim[i]),
      .left_val_i  (left_val),
      .left_tok_i  (left_tok),
      .right_val_i (right_val),
      .right_tok_i (right_tok),
      .val_o       (cell_val[i]),
      .stat_o      (stat[i])
    );

    assign tok[i]    = stat[i].tok;
    assign up_vec[i] = stat[i].up_ok;
    assign dn_vec[i] = stat[i].dn_ok;
  end

  assign up_any = |up_vec;
  assign dn_any = |dn_vec;

  // Entry selected by the request position, for reads.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < N; i++) begin
      if (sel[i]) begin
        rd_val = rd_val | cell_val[i];
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    dir_d        = dir_q;
    pos_d        = pos_q;
    par_d        = par_q;
    len_d        = len_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    rsp_valid_d  = rsp_valid_q;
    rsp_d        = rsp_q;

    ctrl         = '0;
    ctrl.wdata   = req_i.value;

    if (cfg_i.valid) begin
      len_d = cfg_i.list_length;
    end

    // Output register drains the holding slot whenever it is free.
    if (!rsp_valid_q || rsp_o.ready) begin
      rsp_valid_d  = pend_valid_q;
      rsp_d        = pend_q;
      pend_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          pend_d.new_position = req_i.position;
          pend_d.odd_parity   = 1'b0;
          pend_d.read_value   = '0;
          pend_d.bad_position = 1'b0;
          pend_valid_d        = 1'b1;
          unique case (slrp_pkg::op_e'(req_i.op))
            slrp_pkg::OP_LOAD: begin
              pend_d.bad_position = !pos_ok;
              ctrl.load           = pos_ok;
            end
            slrp_pkg::OP_REPLACE: begin
              pend_d.bad_position = !pos_ok;
              if (pos_ok) begin
                ctrl.load    = 1'b1;
                ctrl.seed    = 1'b1;
                pend_valid_d = 1'b0;
                state_d      = ST_MOVE;
                dir_d        = DIR_NONE;
                pos_d        = req_i.position;
                par_d        = 1'b0;
              end
            end
            slrp_pkg::OP_READ: begin
              pend_d.bad_position = !pos_ok;
              if (pos_ok) begin
                pend_d.read_value = rd_val;
              end
            end
            slrp_pkg::OP_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOVE: begin
        if ((dir_q != DIR_DN) && up_any) begin
          ctrl.swap_up = 1'b1;
          dir_d        = DIR_UP;
          pos_d        = pos_q + 1'b1;
          par_d        = !par_q;
        end else if ((dir_q != DIR_UP) && dn_any) begin
          ctrl.swap_dn = 1'b1;
          dir_d        = DIR_DN;
          pos_d        = pos_q - 1'b1;
          par_d        = !par_q;
        end else begin
          ctrl.clr            = 1'b1;
          state_d             = ST_IDLE;
          pend_valid_d        = 1'b1;
          pend_d.new_position = pos_q;
          pend_d.odd_parity   = par_q;
          pend_d.read_value   = '0;
          pend_d.bad_position = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      dir_q        <= DIR_NONE;
      len_q        <= slrp_pkg::LEN_RESET;
      pend_valid_q <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      dir_q        <= dir_d;
      len_q        <= len_d;
      pend_valid_q <= pend_valid_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    par_q  <= par_d;
    pend_q <= pend_d;
    rsp_q  <= rsp_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.new_position = rsp_q.new_position;
  assign rsp_o.odd_parity   = rsp_q.odd_parity;
  assign rsp_o.read_value   = rsp_q.read_value;
  assign rsp_o.bad_position = rsp_q.bad_position;

  // At most one cell carries the moving token.
  a_tok_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok))
    else $error("more than one cell holds the token");

  // While an entry is being moved, exactly one token exists.
  a_tok_in_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE) |-> $onehot(tok))
    else $error("no token while moving an entry");

  // Outside a move no cell holds a token.
  a_tok_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (tok == '0))
    else $error("token left over after a move");

  // A flagged position never reports swaps or read data.
  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.bad_position) |-> (!rsp_q.odd_parity && rsp_q.read_value == '0))
    else $error("bad position response carries data");

endmodule

>>> rtl/core/slrp_cell.sv
module slrp_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slrp_pkg::cell_ctrl_t        ctrl_i,
  input  logic                        sel_i,
  input  logic                        up_lim_i,
  input  logic                        dn_lim_i,
  input  logic [slrp_pkg::VAL_W-1:0]  left_val_i,
  input  logic                        left_tok_i,
  input  logic [slrp_pkg::VAL_W-1:0]  right_val_i,
  input  logic                        right_tok_i,
  output logic [slrp_pkg::VAL_W-1:0]  val_o,
  output slrp_pkg::cell_stat_t        stat_o
);

  logic [slrp_pkg::VAL_W-1:0] val_q, val_d;
  logic                       tok_q, tok_d;

  always_comb begin
    val_d = val_q;
    tok_d = tok_q;
    if (ctrl_i.load && sel_i) begin
      val_d = ctrl_i.wdata;
    end else if (ctrl_i.swap_up) begin
      if (tok_q) begin
        val_d = right_val_i;
      end else if (left_tok_i) begin
        val_d = left_val_i;
      end
    end else if (ctrl_i.swap_dn) begin
      if (tok_q) begin
        val_d = left_val_i;
      end else if (right_tok_i) begin
        val_d = right_val_i;
      end
    end

    if (ctrl_i.seed && sel_i) begin
      tok_d = 1'b1;
    end else if (ctrl_i.clr) begin
      tok_d = 1'b0;
    end else if (ctrl_i.swap_up) begin
      tok_d = left_tok_i;
    end else if (ctrl_i.swap_dn) begin
      tok_d = right_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      tok_q <= 1'b0;
    end else begin
      val_q <= val_d;
      tok_q <= tok_d;
    end
  end

  assign val_o        = val_q;
  assign stat_o.tok   = tok_q;
  assign stat_o.up_ok = tok_q && up_lim_i && (val_q > right_val_i);
  assign stat_o.dn_ok = tok_q && dn_lim_i && (val_q < left_val_i);

endmodule

>>> bench/slrp_list_checker.sv
module slrp_list_checker
  import slrp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  slrp_req_if   req_i,
  slrp_rsp_if   rsp_i,
  slrp_cfg_if   cfg_i,
  output int    fail_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [VAL_W-1:0] cells [MAX_LEN];
  logic [LEN_W-1:0] length_q;
  rsp_t             awaited_rsp [$];
  rsp_t             want;

  // Applies one request to the mirrored list and returns the response it should give.
  function automatic rsp_t apply_request(input op_e op, input logic [POS_W-1:0] pos,
                                         input logic [VAL_W-1:0] val);
    rsp_t             r;
    int unsigned      used;
    int unsigned      p;
    int unsigned      swaps;
    logic [VAL_W-1:0] t;
    r.new_position = pos;
    r.odd_parity   = 1'b0;
    r.read_value   = '0;
    r.bad_position = 1'b0;
    used  = (length_q > MAX_LEN) ? MAX_LEN : length_q;
    p     = pos;
    swaps = 0;
    // The unused op code leaves everything alone and is never flagged.
    if (op != OP_NOP) begin
      if (p >= used) begin
        r.bad_position = 1'b1;
      end else begin
        case (op)
          OP_LOAD: begin
            cells[p] = val;
          end
          OP_READ: begin
            r.read_value = cells[p];
          end
          default: begin
            cells[p] = val;
            // Only the moved entry is compared; equal neighbors stop the walk.
            if (p + 1 < used && cells[p] > cells[p+1]) begin
              while (p + 1 < used && cells[p] > cells[p+1]) begin
                t          = cells[p+1];
                cells[p+1] = cells[p];
                cells[p]   = t;
                p++;
                swaps++;
              end
            end else if (p > 0 && cells[p] < cells[p-1]) begin
              while (p > 0 && cells[p] < cells[p-1]) begin
                t          = cells[p-1];
                cells[p-1] = cells[p];
                cells[p]   = t;
                p--;
                swaps++;
              end
            end
            r.new_position = p[POS_W-1:0];
            r.odd_parity   = swaps[0];
          end
        endcase
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (cells[i]) cells[i] = '0;
      length_q = LEN_RESET;
      awaited_rsp.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // A response here belongs to an earlier request, so check before queuing.
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_rsp.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected response, expected none, actual pos=%0d odd=%0d rd=%h bad=%0d",
                   $time, rsp_i.new_position, rsp_i.odd_parity, rsp_i.read_value,
                   rsp_i.bad_position);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_i.new_position !== want.new_position ||
              rsp_i.odd_parity   !== want.odd_parity   ||
              rsp_i.read_value   !== want.read_value   ||
              rsp_i.bad_position !== want.bad_position) begin
            fail_count_o++;
            $display("%0t: response mismatch, expected pos=%0d odd=%0d rd=%h bad=%0d",
                     $time, want.new_position, want.odd_parity, want.read_value,
                     want.bad_position);
            $display("%0t:                    actual   pos=%0d odd=%0d rd=%h bad=%0d",
                     $time, rsp_i.new_position, rsp_i.odd_parity, rsp_i.read_value,
                     rsp_i.bad_position);
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        length_q = cfg_i.list_length;
      end
      if (req_i.valid && req_i.ready) begin
        awaited_rsp.push_back(apply_request(op_e'(req_i.op), req_i.position, req_i.value));
      end
      pending_o = awaited_rsp.size();
    end
  end

endmodule

>>> bench/tb_sorted_list_resort_with_parity_core.sv
module tb_sorted_list_resort_with_parity_core;
  import slrp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int          fail_count;
  int          pending_count;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_request  = 1'b0;

  slrp_req_if req_bus ();
  slrp_rsp_if rsp_bus ();
  slrp_cfg_if cfg_bus ();

  sorted_list_resort_with_parity_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  slrp_list_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_bus),
    .rsp_i        (rsp_bus),
    .cfg_i        (cfg_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Response side: random stalls, or one long hold-off when asked for.
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input op_e op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.op       <= op;
    req_bus.position <= pos;
    req_bus.value    <= val;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
  endtask

  // Writes the length register once every response is back.
  task automatic set_length(input logic [LEN_W-1:0] len);
    req_bus.valid <= 1'b0;
    wait (pending_count == 0);
    @(negedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.list_length <= len;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len, input int unsigned count,
                           input int unsigned idle, input int unsigned stall, input bit hold);
    int unsigned      used;
    int unsigned      r;
    op_e              op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    set_length(len);
    used          = (len > MAX_LEN) ? MAX_LEN : len;
    send_idle_pct = idle;
    stall_pct     = stall;
    if (hold) hold_request = 1'b1;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 12)      op = OP_LOAD;
      else if (r < 60) op = OP_REPLACE;
      else if (r < 93) op = OP_READ;
      else             op = OP_NOP;
      // Mostly in-range positions so the list stays sorted and replaces walk far.
      if (used == 0 || $urandom_range(9) == 0) pos = POS_W'($urandom_range(MAX_LEN - 1));
      else                                     pos = POS_W'($urandom_range(used - 1));
      // Narrow values make equal neighbors common.
      case ($urandom_range(3))
        0:       val = VAL_W'($urandom_range(7));
        1:       val = $urandom_range(1) ? '1 : '0;
        default: val = VAL_W'($urandom);
      endcase
      send_request(op, pos, val);
    end
  endtask

  initial begin
    req_bus.valid       = 1'b0;
    req_bus.op          = OP_NOP;
    req_bus.position    = '0;
    req_bus.value       = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.list_length = LEN_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset contents at both ends, then a load at the top.
    send_request(OP_READ, 0, 16'h0000);
    send_request(OP_READ, 63, 16'h1234);
    send_request(OP_LOAD, 63, 16'hFFFF);
    send_request(OP_READ, 63, 16'h0000);
    // Long climb that stops at an equal neighbor, then replaces that stay in place.
    send_request(OP_REPLACE, 0, 16'hFFFF);
    send_request(OP_REPLACE, 62, 16'h0000);
    send_request(OP_REPLACE, 63, 16'h0001);
    // Break the order, then climbs with odd swap counts up to the disorder and the top.
    send_request(OP_LOAD, 10, 16'h8000);
    send_request(OP_REPLACE, 0, 16'h0002);
    send_request(OP_REPLACE, 11, 16'h0001);
    send_request(OP_REPLACE, 63, 16'h0000);
    // Walk down to the bottom end.
    send_request(OP_LOAD, 0, 16'h0005);
    send_request(OP_REPLACE, 1, 16'h0000);
    send_request(OP_NOP, 63, 16'hFFFF);
    send_request(OP_NOP, 0, 16'h0000);
    // A zero length flags every position.
    set_length(0);
    send_request(OP_READ, 0, 16'h0000);
    send_request(OP_REPLACE, 0, 16'hFFFF);
    send_request(OP_NOP, 5, 16'h0000);
    // A length above the cell count saturates.
    set_length(127);
    send_request(OP_REPLACE, 63, 16'h0000);
    send_request(OP_READ, 63, 16'h0000);
    // A single entry has no neighbor to move toward.
    set_length(1);
    send_request(OP_REPLACE, 0, 16'hFFFF);
    send_request(OP_READ, 0, 16'h0000);
    send_request(OP_LOAD, 1, 16'h7777);
    send_request(OP_READ, 63, 16'h0000);

    run_phase(64, 120, 0, 0, 1'b1);
    run_phase(LEN_W'($urandom_range(64, 1)), 100, 85, 0, 1'b0);
    run_phase(2, 60, 0, 85, 1'b0);
    run_phase(127, 100, 10, 10, 1'b0);
    run_phase(LEN_W'($urandom_range(127, 65)), 60, 85, 0, 1'b0);
    run_phase(LEN_W'($urandom_range(64, 2)), 100, 0, 85, 1'b0);
    run_phase(64, 40, 0, 0, 1'b0);
    run_phase(1, 20, 10, 10, 1'b0);

    req_bus.valid <= 1'b0;
    wait (pending_count == 0);
    repeat (2 * MAX_LEN) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sorted_list_resort_with_parity_core.f
rtl/core/slrp_pkg.sv
rtl/core/slrp_if.sv
rtl/core/slrp_cell.sv
rtl/core/sorted_list_resort_with_parity_core.sv
bench/slrp_list_checker.sv
bench/tb_sorted_list_resort_with_parity_core.sv
